### sv/stx_etx_frame_receiver_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the framed packet receiver.
// Define NO_ASSERTIONS to compile the checks out.
// ---------------------------------------------------------------------------
`ifndef STX_ETX_FRAME_RECEIVER_CORE_MACROS_SVH
`define STX_ETX_FRAME_RECEIVER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define SEFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SEFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SEFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SEFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### sv/sefr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sefr_pkg
// Byte codes, error codes and the result record of the frame receiver.
// ---------------------------------------------------------------------------
package sefr_pkg;

    // Framing and reply bytes.
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;
    localparam logic [7:0] ACK_BYTE = 8'h06;
    localparam logic [7:0] NAK_BYTE = 8'h15;

    // Abort command code after reset.
    localparam logic [7:0] ABORT_CODE_RESET = 8'h02;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict error codes.
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_CSUM = 2'd1;
    localparam logic [1:0] ERR_ETX  = 2'd2;

    // Width of the packed result tdata (45 bits used, padded to bytes).
    localparam int RESULT_BITS = 45;
    localparam int TDATA_BITS  = 48;

    // One result item; the field order matches the tdata packing from the top
    // bit down (has_payload highest, payload_byte lowest).
    typedef struct packed {
        logic       has_payload;
        logic       abort_request;
        logic [1:0] error_code;
        logic [7:0] reply_byte;
        logic       frame_ok;
        logic [7:0] frame_length;
        logic [7:0] command;
        logic [7:0] payload_index;
        logic [7:0] payload_byte;
    } result_t;

endpackage

### sv/stx_etx_frame_receiver_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stx_etx_frame_receiver_core
// Hunts for STX framed packets in a received byte stream, streams out the
// payload bytes and gives one ACK/NAK verdict per frame.
// ---------------------------------------------------------------------------
//  Channel   Dir   Moves
//  s_axis    in    received bytes (tdata[7:0] = rx_byte)
//  m_axis    out   payload items (tuser 0) and frame verdicts (tuser 1)
//  cfg       in    abort command code write (cfg_data)
//
//  Each byte is handled in the cycle it is accepted; one byte per cycle while s_axis_tready is high.
//  Its result, if any, is registered into the result register, or into the skid register while a result waits.
//  The loops are the phase register, the 8-bit byte count and the 8-bit running sum.
//  A two-entry output (result register plus skid register) lets a byte be
//  taken while a result waits; s_axis_tready drops only when both are full.
//  Reset returns to start-byte hunting with the abort code at 0x02.
// ---------------------------------------------------------------------------
`include "stx_etx_frame_receiver_core_macros.svh"

module stx_etx_frame_receiver_core
    import sefr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Received byte stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_BITS-1:0] m_axis_tdata,   // [7:0] payload_byte,
                                                  // [15:8] payload_index,
                                                  // [23:16] command,
                                                  // [31:24] frame_length,
                                                  // [32] frame_ok,
                                                  // [40:33] reply_byte,
                                                  // [42:41] error_code,
                                                  // [43] abort_request,
                                                  // [44] has_payload,
                                                  // [47:45] zero
    output logic                  m_axis_tuser,   // [0] kind
    // Configuration write.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_data
);

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_CSUM = 3'd4,
        PH_END  = 3'd5
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] abort_code_reg;
    logic [7:0] command_reg, command_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] csum_reg, csum_next;

    logic       out_valid_reg, out_valid_next;
    logic       out_kind_reg, out_kind_next;
    result_t    out_data_reg, out_data_next;
    logic       skid_valid_reg, skid_valid_next;
    logic       skid_kind_reg, skid_kind_next;
    result_t    skid_data_reg, skid_data_next;

    logic       accept;
    logic       pop;
    logic       push;
    logic       res_kind;
    result_t    res;
    logic       etx_ok;
    logic       sum_ok;
    logic [7:0] count_inc;

    // Handshakes: a byte is taken whenever the skid register is free.
    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = out_valid_reg && m_axis_tready;
    assign cfg_ready     = 1'b1;

    assign etx_ok    = (s_axis_tdata == ETX_BYTE);
    assign sum_ok    = (~sum_reg == csum_reg);
    assign count_inc = count_reg + 8'd1;

    // Frame parser: next state and the result the current byte causes.
    always_comb
    begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        csum_next    = csum_reg;
        push         = 1'b0;
        res_kind     = KIND_PAYLOAD;

        res               = '0;
        res.command       = command_reg;
        res.frame_length  = length_reg;
        res.abort_request = (command_reg == abort_code_reg);
        res.has_payload   = (length_reg != 8'd0);

        unique case (phase_reg)
            PH_CMD:
            begin
                command_next = s_axis_tdata;
                phase_next   = PH_LEN;
            end
            PH_LEN:
            begin
                length_next = s_axis_tdata;
                phase_next  = (s_axis_tdata == 8'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA:
            begin
                push              = accept;
                res.payload_byte  = s_axis_tdata;
                res.payload_index = count_reg;
                sum_next          = sum_reg + s_axis_tdata;
                count_next        = count_inc;
                if (count_inc == length_reg)
                begin
                    phase_next = PH_CSUM;
                end
            end
            PH_CSUM:
            begin
                csum_next  = s_axis_tdata;
                phase_next = PH_END;
            end
            PH_END:
            begin
                push           = accept;
                res_kind       = KIND_VERDICT;
                res.frame_ok   = etx_ok && sum_ok;
                res.reply_byte = (etx_ok && sum_ok) ? ACK_BYTE : NAK_BYTE;
                // An end byte fault wins over a checksum fault.
                priority if (!etx_ok)
                    res.error_code = ERR_ETX;
                else if (!sum_ok)
                    res.error_code = ERR_CSUM;
                else
                    res.error_code = ERR_NONE;
                phase_next = PH_HUNT;
            end
            default:
            begin
                // Hunting; unused phase codes behave the same way.
                if (s_axis_tdata == STX_BYTE)
                begin
                    phase_next = PH_CMD;
                    sum_next   = 8'd0;
                    count_next = 8'd0;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    // Output register and skid register steering.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_kind_next  = skid_kind_reg;
        skid_data_next  = skid_data_reg;

        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_kind_next   = skid_kind_reg;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_kind_next  = res_kind;
                out_data_next  = res;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_kind_next  = res_kind;
            skid_data_next  = res;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            abort_code_reg <= ABORT_CODE_RESET;
            command_reg    <= 8'd0;
            length_reg     <= 8'd0;
            count_reg      <= 8'd0;
            sum_reg        <= 8'd0;
            csum_reg       <= 8'd0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= KIND_PAYLOAD;
            out_data_reg   <= '0;
            skid_valid_reg <= 1'b0;
            skid_kind_reg  <= KIND_PAYLOAD;
            skid_data_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                command_reg <= command_next;
                length_reg  <= length_next;
                count_reg   <= count_next;
                sum_reg     <= sum_next;
                csum_reg    <= csum_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                abort_code_reg <= cfg_data;
            end
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_data_reg   <= out_data_next;
            skid_valid_reg <= skid_valid_next;
            skid_kind_reg  <= skid_kind_next;
            skid_data_reg  <= skid_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {{(TDATA_BITS - RESULT_BITS){1'b0}}, out_data_reg};

    // Checks on the output buffering and the verdict contents.
    `SEFR_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid holds a result while the output register is empty")
    `SEFR_ASSERT_NEXT(a_payload_emitted, clk, rst_n, accept && (phase_reg == PH_DATA), m_axis_tvalid, "payload byte accepted but no result presented")
    `SEFR_ASSERT_NOW(a_verdict_reply, clk, rst_n, m_axis_tvalid && (m_axis_tuser == KIND_VERDICT), out_data_reg.frame_ok == (out_data_reg.reply_byte == ACK_BYTE), "verdict reply byte disagrees with frame_ok")

endmodule
